[hdl/hps_pkg.sv]
// Shared types, widths and helpers for the hop probe statistics block.
package hps_pkg;

  localparam int unsigned HOP_W   = 8;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned RTT_W   = 24;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned LOSS_W  = 17;
  localparam int unsigned PROD_W  = RTT_W + CNT_W;
  localparam int unsigned STEP_W  = 5;

  // Quotient bits produced by the shared divider for each division.
  localparam logic [STEP_W-1:0] MEAN_STEPS = STEP_W'(RTT_W);
  localparam logic [STEP_W-1:0] LOSS_STEPS = STEP_W'(LOSS_W);

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_ACCUM,
    ST_MEAN_DIV,
    ST_MEAN_WR,
    ST_LOSS_LOAD,
    ST_LOSS_DIV,
    ST_DONE
  } hps_state_t;

  typedef struct packed {
    logic accept;
    logic update;
    logic div_load_mean;
    logic div_load_loss;
    logic div_step;
    logic mean_wr;
    logic out_load;
  } hps_cmd_t;

  typedef struct packed {
    logic need_mean;
  } hps_sts_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? CNT_MAX : v + CNT_W'(1);
  endfunction

endpackage

[hdl/hps_div.sv]
// Restoring divider that produces one quotient bit per cycle while step is asserted.
module hps_div
  import hps_pkg::*;
(
  input  logic             clk,
  input  logic             load,
  input  logic             step,
  input  logic [CNT_W-1:0] rem_init,
  input  logic [RTT_W-1:0] quo_init,
  input  logic [CNT_W-1:0] divisor,
  output logic [RTT_W-1:0] quotient
);

  logic [CNT_W-1:0] rem_r;
  logic [RTT_W-1:0] quo_r;
  logic [CNT_W-1:0] div_r;
  logic [CNT_W:0]   trial;
  logic             fits;

  // The remainder always stays below the divisor, so it fits in CNT_W bits.
  assign trial = {rem_r, quo_r[RTT_W-1]};
  assign fits  = (trial >= {1'b0, div_r});

  always_ff @(posedge clk) begin
    if (load) begin
      rem_r <= rem_init;
      quo_r <= quo_init;
      div_r <= divisor;
    end else if (step) begin
      rem_r <= fits ? CNT_W'(trial - {1'b0, div_r}) : trial[CNT_W-1:0];
      quo_r <= {quo_r[RTT_W-2:0], fits};
    end
  end

  assign quotient = quo_r;

endmodule

[hdl/hps_ctrl.sv]
// Sequencing state machine for the hop probe statistics block.
module hps_ctrl
  import hps_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  hps_sts_t sts,
  output hps_cmd_t cmd
);

  hps_state_t        state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_nxt = sts.need_mean ? ST_ACCUM : ST_LOSS_LOAD;
      end
      ST_ACCUM: begin
        state_nxt = ST_MEAN_DIV;
        cnt_nxt   = MEAN_STEPS - STEP_W'(1);
      end
      ST_MEAN_DIV: begin
        cnt_nxt = cnt_r - STEP_W'(1);
        if (cnt_r == '0) state_nxt = ST_MEAN_WR;
      end
      ST_MEAN_WR, ST_LOSS_LOAD: begin
        state_nxt = ST_LOSS_DIV;
        cnt_nxt   = LOSS_STEPS - STEP_W'(1);
      end
      ST_LOSS_DIV: begin
        cnt_nxt = cnt_r - STEP_W'(1);
        if (cnt_r == '0) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE:      cmd.accept        = in_valid;
      ST_UPDATE:    cmd.update        = 1'b1;
      ST_ACCUM:     cmd.div_load_mean = 1'b1;
      ST_MEAN_DIV:  cmd.div_step      = 1'b1;
      ST_MEAN_WR: begin
        cmd.mean_wr       = 1'b1;
        cmd.div_load_loss = 1'b1;
      end
      ST_LOSS_LOAD: cmd.div_load_loss = 1'b1;
      ST_LOSS_DIV:  cmd.div_step      = 1'b1;
      ST_DONE:      cmd.out_load      = out_free;
      default:      cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

[hdl/hps_dp.sv]
// Statistics registers, mean multiplier, shared divider and result register.
module hps_dp
  import hps_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  hps_cmd_t          cmd,
  output hps_sts_t          sts,
  input  logic              in_first_of_hop,
  input  logic [HOP_W-1:0]  in_hop_number,
  input  logic              in_success,
  input  logic [RTT_W-1:0]  in_rtt_us,
  input  logic [ADDR_W-1:0] in_responder_addr,
  input  logic              in_addr_valid,
  input  logic              in_reached_dest,
  output logic [HOP_W-1:0]  out_hop_out,
  output logic [CNT_W-1:0]  out_sent_count,
  output logic [CNT_W-1:0]  out_reply_count,
  output logic [CNT_W-1:0]  out_timeout_count,
  output logic [RTT_W-1:0]  out_last_rtt,
  output logic [RTT_W-1:0]  out_min_rtt,
  output logic [RTT_W-1:0]  out_max_rtt,
  output logic [RTT_W-1:0]  out_mean_rtt,
  output logic [LOSS_W-1:0] out_loss_ratio,
  output logic              out_dest_seen,
  output logic [ADDR_W-1:0] out_last_addr,
  output logic              out_addr_known
);

  // Latched transaction.
  logic              first_r, ok_r, avalid_r, dest_r;
  logic [HOP_W-1:0]  hopin_r;
  logic [RTT_W-1:0]  rtt_r;
  logic [ADDR_W-1:0] addrin_r;

  // Running statistics.
  logic [HOP_W-1:0]  hop_r, hop_nxt;
  logic [CNT_W-1:0]  sent_r, sent_nxt;
  logic [CNT_W-1:0]  reply_r, reply_nxt;
  logic [CNT_W-1:0]  tmo_r, tmo_nxt;
  logic [RTT_W-1:0]  last_r, last_nxt;
  logic [RTT_W-1:0]  min_r, min_nxt;
  logic [RTT_W-1:0]  max_r, max_nxt;
  logic [RTT_W-1:0]  mean_r, mean_nxt;
  logic              destf_r, destf_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic              addrf_r, addrf_nxt;

  logic [PROD_W-1:0] prod_r;
  logic [PROD_W:0]   acc;
  logic [CNT_W-1:0]  div_rem_init;
  logic [RTT_W-1:0]  div_quo_init;
  logic [CNT_W-1:0]  div_divisor;
  logic [RTT_W-1:0]  quotient;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      first_r  <= in_first_of_hop;
      hopin_r  <= in_hop_number;
      ok_r     <= in_success;
      rtt_r    <= in_rtt_us;
      addrin_r <= in_responder_addr;
      avalid_r <= in_addr_valid;
      dest_r   <= in_reached_dest;
    end
  end

  // A later reply of the hop needs the division for the running mean.
  assign sts.need_mean = ok_r && !first_r && (reply_r != '0);

  always_comb begin
    logic [CNT_W-1:0] sent_b, reply_b, tmo_b;
    logic [RTT_W-1:0] min_b, max_b;
    sent_b    = first_r ? '0 : sent_r;
    reply_b   = first_r ? '0 : reply_r;
    tmo_b     = first_r ? '0 : tmo_r;
    min_b     = first_r ? '0 : min_r;
    max_b     = first_r ? '0 : max_r;
    hop_nxt   = first_r ? hopin_r : hop_r;
    last_nxt  = first_r ? '0 : last_r;
    mean_nxt  = first_r ? '0 : mean_r;
    destf_nxt = first_r ? 1'b0 : destf_r;
    addr_nxt  = first_r ? '0 : addr_r;
    addrf_nxt = first_r ? 1'b0 : addrf_r;
    min_nxt   = min_b;
    max_nxt   = max_b;
    reply_nxt = reply_b;
    tmo_nxt   = tmo_b;
    sent_nxt  = sat_inc(sent_b);
    if (!ok_r) begin
      tmo_nxt = sat_inc(tmo_b);
    end else begin
      reply_nxt = sat_inc(reply_b);
      last_nxt  = rtt_r;
      if (avalid_r) begin
        addr_nxt  = addrin_r;
        addrf_nxt = 1'b1;
      end
      if (dest_r) destf_nxt = 1'b1;
      if (reply_b == '0) begin
        min_nxt  = rtt_r;
        max_nxt  = rtt_r;
        mean_nxt = rtt_r;
      end else begin
        if (rtt_r < min_b) min_nxt = rtt_r;
        if (rtt_r > max_b) max_nxt = rtt_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hop_r   <= '0;
      sent_r  <= '0;
      reply_r <= '0;
      tmo_r   <= '0;
      last_r  <= '0;
      min_r   <= '0;
      max_r   <= '0;
      mean_r  <= '0;
      destf_r <= 1'b0;
      addr_r  <= '0;
      addrf_r <= 1'b0;
    end else if (cmd.update) begin
      hop_r   <= hop_nxt;
      sent_r  <= sent_nxt;
      reply_r <= reply_nxt;
      tmo_r   <= tmo_nxt;
      last_r  <= last_nxt;
      min_r   <= min_nxt;
      max_r   <= max_nxt;
      mean_r  <= mean_nxt;
      destf_r <= destf_nxt;
      addr_r  <= addr_nxt;
      addrf_r <= addrf_nxt;
    end else if (cmd.mean_wr) begin
      mean_r <= quotient;
    end
  end

  // Old mean times (n - 1), with n the reply count after this reply.
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      prod_r <= PROD_W'(mean_r) * PROD_W'(reply_nxt - CNT_W'(1));
    end
  end

  assign acc = {1'b0, prod_r} + (PROD_W + 1)'(rtt_r);

  // The quotient of each division is known to fit its field, so the bits
  // above the quotient width start out as the remainder.
  always_comb begin
    if (cmd.div_load_mean) begin
      div_rem_init = acc[PROD_W-1:RTT_W];
      div_quo_init = acc[RTT_W-1:0];
      div_divisor  = reply_r;
    end else begin
      div_rem_init = {1'b0, tmo_r[CNT_W-1:1]};
      div_quo_init = {tmo_r[0], {(RTT_W-1){1'b0}}};
      div_divisor  = sent_r;
    end
  end

  hps_div u_div (
    .clk      (clk),
    .load     (cmd.div_load_mean || cmd.div_load_loss),
    .step     (cmd.div_step),
    .rem_init (div_rem_init),
    .quo_init (div_quo_init),
    .divisor  (div_divisor),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_hop_out       <= hop_r;
      out_sent_count    <= sent_r;
      out_reply_count   <= reply_r;
      out_timeout_count <= tmo_r;
      out_last_rtt      <= last_r;
      out_min_rtt       <= min_r;
      out_max_rtt       <= max_r;
      out_mean_rtt      <= mean_r;
      out_loss_ratio    <= quotient[LOSS_W-1:0];
      out_dest_seen     <= destf_r;
      out_last_addr     <= addr_r;
      out_addr_known    <= addrf_r;
    end
  end

endmodule

[hdl/hop_probe_statistics.sv]
// Top level of the per-hop probe statistics block.
//
//   channel  | handshake           | payload
//   ---------+---------------------+--------------------------------------------
//   in_      | in_valid / in_stall | one probe outcome per transaction
//   out_     | out_valid/out_stall | statistics snapshot after each probe
//
// Each probe transaction holds the block from its acceptance until its
// snapshot is loaded. A running mean is computed only for a later reply of
// the hop; the mean division is skipped otherwise. The shared divider
// produces one quotient bit per cycle while the controller steps it: 24
// steps for the running mean and 17 steps for the loss ratio. The input is
// taken only while the controller is idle. The result sits in its own output
// register, so a new probe is accepted while an earlier snapshot still waits
// on out_stall; the next snapshot is held back until that one is taken.
// Reset is synchronous and clears all statistics and the control state.
module hop_probe_statistics
  import hps_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_first_of_hop,
  input  logic [HOP_W-1:0]  in_hop_number,
  input  logic              in_success,
  input  logic [RTT_W-1:0]  in_rtt_us,
  input  logic [ADDR_W-1:0] in_responder_addr,
  input  logic              in_addr_valid,
  input  logic              in_reached_dest,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [HOP_W-1:0]  out_hop_out,
  output logic [CNT_W-1:0]  out_sent_count,
  output logic [CNT_W-1:0]  out_reply_count,
  output logic [CNT_W-1:0]  out_timeout_count,
  output logic [RTT_W-1:0]  out_last_rtt,
  output logic [RTT_W-1:0]  out_min_rtt,
  output logic [RTT_W-1:0]  out_max_rtt,
  output logic [RTT_W-1:0]  out_mean_rtt,
  output logic [LOSS_W-1:0] out_loss_ratio,
  output logic              out_dest_seen,
  output logic [ADDR_W-1:0] out_last_addr,
  output logic              out_addr_known
);

  hps_cmd_t cmd;
  hps_sts_t sts;

  // The controller steps through update, the mean division when it is needed
  // and the loss division, and owns the output valid flag.
  hps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the statistics, the multiplier for the running mean,
  // the shared divider and the result snapshot.
  hps_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_first_of_hop   (in_first_of_hop),
    .in_hop_number     (in_hop_number),
    .in_success        (in_success),
    .in_rtt_us         (in_rtt_us),
    .in_responder_addr (in_responder_addr),
    .in_addr_valid     (in_addr_valid),
    .in_reached_dest   (in_reached_dest),
    .out_hop_out       (out_hop_out),
    .out_sent_count    (out_sent_count),
    .out_reply_count   (out_reply_count),
    .out_timeout_count (out_timeout_count),
    .out_last_rtt      (out_last_rtt),
    .out_min_rtt       (out_min_rtt),
    .out_max_rtt       (out_max_rtt),
    .out_mean_rtt      (out_mean_rtt),
    .out_loss_ratio    (out_loss_ratio),
    .out_dest_seen     (out_dest_seen),
    .out_last_addr     (out_last_addr),
    .out_addr_known    (out_addr_known)
  );

endmodule
